// ===== rtl/pcm_to_float32_convert_core_defines.svh =====
// ----------------------------------------------------------------------------
// PCM to float32 converter: assertion macros
// Shared concurrent assertion wrappers, compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef PCM_TO_FLOAT32_CONVERT_CORE_DEFINES_SVH
`define PCM_TO_FLOAT32_CONVERT_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// clocked check, off while reset is high
`define PCMF_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("pcmf assertion failed");
// clocked check, also active during reset
`define PCMF_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("pcmf assertion failed");
`else
`define PCMF_ASSERT(lbl, clk, rst, prop)
`define PCMF_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== rtl/pcmf_pkg.sv =====
// ----------------------------------------------------------------------------
// PCM to float32 converter: package
// Format codes, register map and the round-and-pack helper.
// ----------------------------------------------------------------------------
package pcmf_pkg;

   // sample format codes
   localparam logic [2:0] FMT_U8    = 3'd0;
   localparam logic [2:0] FMT_S8    = 3'd1;
   localparam logic [2:0] FMT_S16   = 3'd2;
   localparam logic [2:0] FMT_S32   = 3'd3;
   localparam logic [2:0] FMT_FLOAT = 3'd4;
   localparam logic [2:0] FMT_RESET = FMT_S16;

   // register map
   localparam int unsigned CSR_ADDR_W = 3;
   localparam logic        REG_SAMPLE_FORMAT = 1'b0;   // index taken from paddr[2]

   // significand of float(1/127): value = INV127_SIG * 2^-30
   localparam logic [23:0] INV127_SIG = 24'h810204;

   // fixed results for the S16 corner cases
   localparam logic [30:0] F_ONE          = 31'h3F800000;  // 1.0
   localparam logic [30:0] F_ONE_PLUS_ULP = 31'h3F800100;  // 1 + 2^-15

   typedef logic [31:0] fbits_type;

   // Round magnitude * 2^scale to single precision, nearest even.
   // sticky_in flags nonzero bits below the LSB of mag.
   function automatic fbits_type round_pack(input logic        sign,
                                            input logic [47:0] mag,
                                            input logic        sticky_in,
                                            input logic [8:0]  scale);
      logic [47:0] m;
      logic [5:0]  lz;
      logic [23:0] mant;
      logic        guard;
      logic        sticky;
      logic        up;
      logic [24:0] sum;
      logic [8:0]  ex;
      logic [22:0] frac;
      m  = mag;
      lz = '0;
      // log shifter normalize
      if (m[47:16] == '0) begin m = m << 32; lz[5] = 1'b1; end
      if (m[47:32] == '0) begin m = m << 16; lz[4] = 1'b1; end
      if (m[47:40] == '0) begin m = m << 8;  lz[3] = 1'b1; end
      if (m[47:44] == '0) begin m = m << 4;  lz[2] = 1'b1; end
      if (m[47:46] == '0) begin m = m << 2;  lz[1] = 1'b1; end
      if (m[47] == 1'b0)  begin m = m << 1;  lz[0] = 1'b1; end
      mant   = m[47:24];
      guard  = m[23];
      sticky = (|m[22:0]) | sticky_in;
      up     = guard & (sticky | mant[0]);
      sum    = {1'b0, mant} + {24'd0, up};
      ex     = 9'd174 - {3'd0, lz} + scale;
      if (sum[24]) begin
         ex   = ex + 9'd1;
         frac = '0;
      end else begin
         frac = sum[22:0];
      end
      if (mag == '0) begin
         round_pack = '0;
      end else begin
         round_pack = {sign, ex[7:0], frac};
      end
   endfunction

endpackage

// ===== rtl/pcmf_convert.sv =====
// ----------------------------------------------------------------------------
// PCM to float32 converter: datapath
// Combinational conversion of one sample word to a float32 pattern.
// ----------------------------------------------------------------------------
module pcmf_convert (
   input  logic [2:0]  sample_format,
   input  logic [31:0] sample_word,
   output logic [31:0] float_bits
);
   import pcmf_pkg::*;

   logic [8:0]  v8;
   logic        sgn8;
   logic [8:0]  abs8;
   logic [31:0] prod8;
   logic        sgn16;
   logic [15:0] abs16;
   logic [47:0] rep16;
   logic        sgn32;
   logic [31:0] abs32;

   // 8-bit formats: |v| * float(1/127), exact product then round
   always_comb begin
      if (sample_format == FMT_U8) begin
         v8 = {1'b0, sample_word[7:0]} - 9'd128;
      end else begin
         v8 = {sample_word[7], sample_word[7:0]};
      end
      sgn8  = v8[8];
      abs8  = sgn8 ? (9'd0 - v8) : v8;
      // magnitude reaches 128, so eight bits of abs8 take part
      prod8 = {23'd0, abs8} * {8'd0, INV127_SIG};
   end

   // 16-bit: a/32767 is the 15-bit block of a repeated
   always_comb begin
      sgn16 = sample_word[15];
      abs16 = sgn16 ? (16'd0 - sample_word[15:0]) : sample_word[15:0];
      rep16 = {3'd0, abs16[14:0], abs16[14:0], abs16[14:0]};
   end

   // 32-bit magnitude
   always_comb begin
      sgn32 = sample_word[31];
      abs32 = sgn32 ? (32'd0 - sample_word) : sample_word;
   end

   // format select
   always_comb begin
      case (sample_format)
         FMT_U8, FMT_S8: begin
            float_bits = round_pack(sgn8, {16'd0, prod8}, 1'b0, 9'h1E2);   // 2^-30
         end
         FMT_S16: begin
            if (abs16 == 16'd32767) begin
               float_bits = {sgn16, F_ONE};
            end else if (abs16 == 16'd32768) begin
               float_bits = {1'b1, F_ONE_PLUS_ULP};
            end else begin
               float_bits = round_pack(sgn16, rep16, 1'b1, 9'h1D3);       // 2^-45
            end
         end
         FMT_S32: begin
            float_bits = round_pack(sgn32, {16'd0, abs32}, 1'b0, 9'h1E1);  // 2^-31
         end
         FMT_FLOAT: begin
            float_bits = sample_word;
         end
         default: begin
            float_bits = '0;
         end
      endcase
   end

endmodule

// ===== rtl/pcm_to_float32_convert_core.sv =====
// ----------------------------------------------------------------------------
// PCM to float32 converter: top level
// Converts PCM sample beats to IEEE-754 single precision, format from CSR.
// ----------------------------------------------------------------------------
//  channel   dir  ports                          payload
//  req       in   req_tvalid/tready/tdata/tlast  sample_word, sample_last
//  rsp       out  rsp_tvalid/tready/tdata/tlast  float_bits, result_last
//  csr       in   APB csr_psel..csr_pready       sample_format @ 0x0
//
//  One beat per cycle unless rsp stalls; a result shows in the next cycle.
//  The whole conversion sits between the input and the result register.
//  Reset sets sample_format to signed 16-bit and empties the result stage.
//  A new beat is taken while the result register is empty or being drained.
// ----------------------------------------------------------------------------
`include "pcm_to_float32_convert_core_defines.svh"

module pcm_to_float32_convert_core (
   input  logic                          clock,
   input  logic                          reset,
   // input stream
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [31:0]                   req_tdata,   // [31:0] sample_word
   input  logic                          req_tlast,
   // result stream
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [31:0]                   rsp_tdata,   // [31:0] float_bits
   output logic                          rsp_tlast,
   // config
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [pcmf_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready
);
   import pcmf_pkg::*;

   logic [2:0]  fmt_ff;
   logic [2:0]  fmt_in;
   logic        valid_ff;
   logic        valid_in;
   logic [31:0] data_ff;
   logic [31:0] data_in;
   logic        last_ff;
   logic        last_in;
   logic        req_beat;
   logic        csr_wr;
   logic [31:0] conv_bits;

   // config register
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      fmt_in = fmt_ff;
      if (csr_wr && (csr_paddr[2] == REG_SAMPLE_FORMAT)) begin
         fmt_in = csr_pwdata[2:0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_SAMPLE_FORMAT) ? {29'd0, fmt_ff} : 32'd0;

   // conversion
   pcmf_convert u_convert (
      .sample_format (fmt_ff),
      .sample_word   (req_tdata),
      .float_bits    (conv_bits)
   );

   // result register
   assign req_tready = !valid_ff || rsp_tready;
   assign req_beat   = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      last_in  = last_ff;
      if (req_beat) begin
         valid_in = 1'b1;
         data_in  = conv_bits;
         last_in  = req_tlast;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff   <= FMT_RESET;
         valid_ff <= 1'b0;
      end else begin
         fmt_ff   <= fmt_in;
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;

   // checks
   `PCMF_ASSERT(a_no_take_when_blocked, clock, reset, (rsp_tvalid && !rsp_tready) |-> !req_tready)
   `PCMF_ASSERT(a_beat_gives_result, clock, reset, req_beat |=> rsp_tvalid)
   `PCMF_ASSERT(a_passthrough, clock, reset, (req_beat && fmt_ff == FMT_FLOAT) |=> (rsp_tdata == $past(req_tdata)))
   `PCMF_ASSERT(a_zero_s32, clock, reset, (req_beat && fmt_ff == FMT_S32 && req_tdata == 32'd0) |=> (rsp_tdata == 32'd0))
   `PCMF_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_tvalid)

endmodule

// ===== dv/pcm_to_float32_convert_checker.sv =====
// ----------------------------------------------------------------------------
// PCM to float32 converter: stream checker
// Watches the CSR writes and both streams, predicts each float32 result
// with exact integer arithmetic and compares it with the returned beat.
// ----------------------------------------------------------------------------
module pcm_to_float32_convert_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,
   input  logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          fail_count,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import pcmf_pkg::*;

   // significand of float(1/127), value = sig * 2^-30
   localparam logic [63:0] RECIP127_SIG = 64'h810204;

   typedef struct packed {
      logic [31:0] float_bits;
      logic        result_last;
   } float_beat_type;

   float_beat_type expected_floats[$];
   logic [2:0]     fmt_shadow;

   // round sign * (mag + sticky) * 2^e to single precision, nearest even
   function automatic logic [31:0] round_to_single(input logic sign, input logic [63:0] mag,
                                                   input logic sticky, input int e);
      int          msb;
      int          sh;
      logic [63:0] mant;
      logic        guard;
      logic        rest;
      logic [7:0]  ex;
      if (mag == 0) return 32'd0;
      msb = 0;
      for (int i = 0; i < 64; i++) if (mag[i]) msb = i;
      if (msb > 23) begin
         sh    = msb - 23;
         mant  = mag >> sh;
         guard = mag[sh-1];
         rest  = sticky | ((mag & ((64'd1 << (sh - 1)) - 1)) != 0);
         if (guard && (rest || mant[0])) mant = mant + 1;
         if (mant[24]) begin
            mant = mant >> 1;
            msb  = msb + 1;
         end
      end else begin
         mant = mag << (23 - msb);
      end
      ex = 8'(msb + e + 127);
      return {sign, ex, mant[22:0]};
   endfunction

   function automatic logic [31:0] predict_float(input logic [31:0] w, input logic [2:0] fmt);
      logic signed [63:0] v;
      logic [63:0]        m;
      logic               neg;
      case (fmt)
         FMT_U8, FMT_S8: begin
            if (fmt == FMT_U8) v = $signed({56'd0, w[7:0]}) - 128;
            else               v = {{56{w[7]}}, w[7:0]};
            neg = v < 0;
            m   = neg ? -v : v;
            return round_to_single(neg, m * RECIP127_SIG, 1'b0, -30);
         end
         FMT_S16: begin
            v   = {{48{w[15]}}, w[15:0]};
            neg = v < 0;
            m   = (neg ? -v : v) << 40;
            return round_to_single(neg, m / 32767, (m % 32767) != 0, -40);
         end
         FMT_S32: begin
            v   = {{32{w[31]}}, w};
            neg = v < 0;
            m   = neg ? -v : v;
            return round_to_single(neg, m, 1'b0, -31);
         end
         FMT_FLOAT: return w;
         default:   return 32'd0;
      endcase
   endfunction

   always @(posedge clock) begin
      float_beat_type got;
      float_beat_type want;
      int             errs;
      errs = 0;
      if (reset) begin
         fmt_shadow <= FMT_RESET;
         fail_count <= 0;
         expected_floats.delete();
         pending    <= 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr[2] == REG_SAMPLE_FORMAT)
            fmt_shadow <= csr_pwdata[2:0];
         if (req_tvalid && req_tready)
            expected_floats.push_back('{predict_float(req_tdata, fmt_shadow), req_tlast});
         if (rsp_tvalid && rsp_tready) begin
            got = '{rsp_tdata, rsp_tlast};
            if (expected_floats.size() == 0) begin
               $error("result beat with nothing expected: float_bits %h", got.float_bits);
               errs++;
            end else begin
               want = expected_floats.pop_front();
               if (got.float_bits !== want.float_bits) begin
                  $error("float_bits: expected %h, actual %h", want.float_bits, got.float_bits);
                  errs++;
               end
               if (got.result_last !== want.result_last) begin
                  $error("result_last: expected %b, actual %b",
                         want.result_last, got.result_last);
                  errs++;
               end
            end
         end
         fail_count <= fail_count + errs;
         pending    <= expected_floats.size();
      end
   end
endmodule

// ===== dv/tb_pcm_to_float32_convert_core.sv =====
// ----------------------------------------------------------------------------
// PCM to float32 converter: testbench top
// Drives directed and random sample beats over the format codes, with random
// gaps, a long result stall and idle phase boundaries; the checker judges.
// ----------------------------------------------------------------------------
module tb_pcm_to_float32_convert_core;
   timeunit 1ns;
   timeprecision 1ps;
   import pcmf_pkg::*;

   localparam int IDLE_LIMIT = 3000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;    // [31:0] sample_word
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;    // [31:0] float_bits
   logic        rsp_tlast;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   int          fail_count;
   int          pending;
   int          idle_cycles;
   int          max_gap_tx;
   int          max_gap_rx;
   int          rx_beats;

   pcm_to_float32_convert_core i_dut (.*);

   pcm_to_float32_convert_checker i_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog on cycles without any beat or register access
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // result side: random hold-offs, one long stall to back up the input
   initial begin
      int gap;
      rsp_tready = 1'b0;
      rx_beats   = 0;
      max_gap_rx = 7;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rx_beats % 100 == 0) max_gap_rx = ($urandom_range(0, 2) == 0) ? 0 : 7;
         gap = $urandom_range(0, max_gap_rx);
         if (rx_beats == 300) gap = 200;
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(negedge clock);
         while (!rsp_tvalid) @(negedge clock);
         @(posedge clock);
         rx_beats++;
      end
   end

   task automatic send_sample(input logic [31:0] word, input logic last);
      int gap;
      gap = $urandom_range(0, max_gap_tx);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      req_tlast  <= last;
      @(negedge clock);
      while (!req_tready) @(negedge clock);
      @(posedge clock);
   endtask

   // let the stream drain before touching the register
   task automatic drain_stream();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_format(input logic [2:0] fmt);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= 3'd0;
      csr_pwdata  <= {29'($urandom), fmt};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [31:0] random_word();
      logic [31:0] w;
      w = $urandom;
      case ($urandom_range(0, 5))
         0: w = {$urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000, w[7:0]};
         1: w[15:0] = $urandom_range(0, 1) ? 16'(16'h8000 + $urandom_range(0, 3))
                                          : 16'(16'h7FFF - $urandom_range(0, 3));
         2: w = $urandom_range(0, 1) ? 32'h8000_0000 + $urandom_range(0, 255)
                                     : 32'h7FFF_FFFF - $urandom_range(0, 255);
         3: w = {w[31], 8'hFF, w[22:0]};
         default: ;
      endcase
      return w;
   endfunction

   initial begin
      logic [31:0] directed_words[12];
      logic [2:0]  fmt;
      directed_words = '{32'h0000_0000, 32'hFFFF_FF7F, 32'h0000_0080, 32'h1234_56FF,
                         32'hABCD_7FFF, 32'h0000_8000, 32'h5A5A_FFFF, 32'h8000_0000,
                         32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h7FC1_2345, 32'h0000_0001};
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tlast   = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      max_gap_tx  = 7;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed corners at the reset format, then passthrough
      foreach (directed_words[i]) send_sample(directed_words[i], i[0]);
      drain_stream();
      write_format(FMT_FLOAT);
      foreach (directed_words[i]) send_sample(directed_words[i], ~i[0]);
      drain_stream();

      // random phases over codes 0 and 2 to 7, then random codes 0 to 5, extremes first
      for (int ph = 0; ph < 16; ph++) begin
         if (ph == 0)      fmt = FMT_U8;
         else if (ph == 1) fmt = 3'd7;
         else if (ph < 8)  fmt = 3'(ph);
         else              fmt = 3'($urandom_range(0, 5));
         write_format(fmt);
         max_gap_tx = ($urandom_range(0, 2) == 0) ? 0 : 7;
         for (int n = 0; n < 100; n++) begin
            if (n % 25 == 0) max_gap_tx = ($urandom_range(0, 2) == 0) ? 0 : 7;
            send_sample(random_word(), $urandom_range(0, 1));
         end
         drain_stream();
      end

      repeat (20) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule
